// ----- design/hsp_pkg.sv -----
package hsp_pkg;

    localparam int COORD_BITS   = 10;
    localparam int FRAC_BITS    = 16;
    localparam int BRIGHT_BITS  = 7;
    localparam int BRIGHT_MAX   = 100;
    localparam int CFG_RESET    = 100;
    localparam int CFG_IDX_BITS = 1;
    localparam int CH_BITS      = 16;
    localparam int SECTOR_BITS  = 3;

    localparam logic [CH_BITS-1:0] FULL_SCALE = 16'd65025;

    localparam logic [SECTOR_BITS-1:0] SEC_1 = 3'd1;
    localparam logic [SECTOR_BITS-1:0] SEC_2 = 3'd2;
    localparam logic [SECTOR_BITS-1:0] SEC_3 = 3'd3;
    localparam logic [SECTOR_BITS-1:0] SEC_4 = 3'd4;
    localparam logic [SECTOR_BITS-1:0] SEC_5 = 3'd5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
    } t_rgb;

endpackage

// ----- design/hsp_div_pipe.sv -----
module hsp_div_pipe #(
    parameter int NB = 29,
    parameter int DB = 11,
    parameter int QB = 19
) (
    input  logic          i_clk,
    input  logic          i_adv,
    input  logic [NB-1:0] i_num,
    input  logic [DB-1:0] i_den,
    output logic [QB-1:0] o_quo
);

    logic [DB-1:0] r_rem [QB-1];
    logic [QB-1:0] r_low [QB-1];
    logic [QB-1:0] r_quo [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [DB-1:0] w_rem_in;
        logic [QB-1:0] w_low_in;
        logic [QB-1:0] w_quo_in;
        logic [DB:0]   w_trial;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = DB'(i_num[NB-1:QB]);
            assign w_low_in = i_num[QB-1:0];
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_low_in = r_low[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        assign w_trial = {w_rem_in, w_low_in[QB-1]};
        assign w_ge    = (w_trial >= {1'b0, i_den});

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_quo[k] <= {w_quo_in[QB-2:0], w_ge};
            end
        end

        if (k < QB - 1) begin : g_carry
            logic [DB:0] n_diff;
            assign n_diff = w_trial - {1'b0, i_den};
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[k] <= w_ge ? n_diff[DB-1:0] : w_trial[DB-1:0];
                    r_low[k] <= {w_low_in[QB-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[QB-1];

endmodule

// ----- design/hsp_calc.sv -----
module hsp_calc #(
    parameter int FRAC_BITS = hsp_pkg::FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_vld,
    input  logic [hsp_pkg::SECTOR_BITS-1:0] i_sector,
    input  logic [FRAC_BITS-1:0]            i_frac,
    input  logic [FRAC_BITS:0]              i_sat,
    input  logic [FRAC_BITS:0]              i_val,
    output logic                            o_vld,
    output hsp_pkg::t_rgb                   o_rgb
);

    localparam int PW = 2 * FRAC_BITS + 2;
    localparam int CW = FRAC_BITS + 1 + hsp_pkg::CH_BITS;
    localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    logic [3:0] r_vld;

    logic [PW-1:0] w_p_prod;
    logic [PW-1:0] w_sf_prod;
    logic [PW-1:0] w_sf2_prod;
    logic [FRAC_BITS:0] r_s1_p;
    logic [FRAC_BITS:0] r_s1_sf;
    logic [FRAC_BITS:0] r_s1_sf2;
    logic [FRAC_BITS:0] r_s1_v;
    logic [hsp_pkg::SECTOR_BITS-1:0] r_s1_sec;
    logic r_s1_vz;
    logic r_s1_sz;

    logic [PW-1:0] w_q_prod;
    logic [PW-1:0] w_t_prod;
    logic [FRAC_BITS:0] r_s2_p;
    logic [FRAC_BITS:0] r_s2_q;
    logic [FRAC_BITS:0] r_s2_t;
    logic [FRAC_BITS:0] r_s2_v;
    logic [hsp_pkg::SECTOR_BITS-1:0] r_s2_sec;
    logic r_s2_vz;
    logic r_s2_sz;

    logic [FRAC_BITS:0] n_r;
    logic [FRAC_BITS:0] n_g;
    logic [FRAC_BITS:0] n_b;
    logic [FRAC_BITS:0] r_s3_r;
    logic [FRAC_BITS:0] r_s3_g;
    logic [FRAC_BITS:0] r_s3_b;

    logic [CW-1:0] w_red_prod;
    logic [CW-1:0] w_green_prod;
    logic [CW-1:0] w_blue_prod;
    hsp_pkg::t_rgb r_s4_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    assign w_p_prod   = PW'(i_val) * PW'(ONE_Q - i_sat);
    assign w_sf_prod  = PW'(i_sat) * PW'(i_frac);
    assign w_sf2_prod = PW'(i_sat) * PW'(ONE_Q - {1'b0, i_frac});

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_p   <= w_p_prod[2*FRAC_BITS:FRAC_BITS];
            r_s1_sf  <= w_sf_prod[2*FRAC_BITS:FRAC_BITS];
            r_s1_sf2 <= w_sf2_prod[2*FRAC_BITS:FRAC_BITS];
            r_s1_v   <= i_val;
            r_s1_sec <= i_sector;
            r_s1_vz  <= (i_val == '0);
            r_s1_sz  <= (i_sat == '0);
        end
    end

    assign w_q_prod = PW'(r_s1_v) * PW'(ONE_Q - r_s1_sf);
    assign w_t_prod = PW'(r_s1_v) * PW'(ONE_Q - r_s1_sf2);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_p   <= r_s1_p;
            r_s2_q   <= w_q_prod[2*FRAC_BITS:FRAC_BITS];
            r_s2_t   <= w_t_prod[2*FRAC_BITS:FRAC_BITS];
            r_s2_v   <= r_s1_v;
            r_s2_sec <= r_s1_sec;
            r_s2_vz  <= r_s1_vz;
            r_s2_sz  <= r_s1_sz;
        end
    end

    // Sector six and unused codes fall through to sector nought.
    always_comb begin
        case (r_s2_sec)
            hsp_pkg::SEC_1: begin
                n_r = r_s2_q; n_g = r_s2_v; n_b = r_s2_p;
            end
            hsp_pkg::SEC_2: begin
                n_r = r_s2_p; n_g = r_s2_v; n_b = r_s2_t;
            end
            hsp_pkg::SEC_3: begin
                n_r = r_s2_p; n_g = r_s2_q; n_b = r_s2_v;
            end
            hsp_pkg::SEC_4: begin
                n_r = r_s2_t; n_g = r_s2_p; n_b = r_s2_v;
            end
            hsp_pkg::SEC_5: begin
                n_r = r_s2_v; n_g = r_s2_p; n_b = r_s2_q;
            end
            default: begin
                n_r = r_s2_v; n_g = r_s2_t; n_b = r_s2_p;
            end
        endcase
        if (r_s2_vz) begin
            n_r = '0; n_g = '0; n_b = '0;
        end else if (r_s2_sz) begin
            n_r = r_s2_v; n_g = r_s2_v; n_b = r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s3_r <= n_r;
            r_s3_g <= n_g;
            r_s3_b <= n_b;
        end
    end

    assign w_red_prod   = CW'(r_s3_r) * CW'(hsp_pkg::FULL_SCALE);
    assign w_green_prod = CW'(r_s3_g) * CW'(hsp_pkg::FULL_SCALE);
    assign w_blue_prod  = CW'(r_s3_b) * CW'(hsp_pkg::FULL_SCALE);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s4_rgb.red   <= w_red_prod[FRAC_BITS+hsp_pkg::CH_BITS-1:FRAC_BITS];
            r_s4_rgb.green <= w_green_prod[FRAC_BITS+hsp_pkg::CH_BITS-1:FRAC_BITS];
            r_s4_rgb.blue  <= w_blue_prod[FRAC_BITS+hsp_pkg::CH_BITS-1:FRAC_BITS];
        end
    end

    assign o_vld = r_vld[3];
    assign o_rgb = r_s4_rgb;

endmodule

// ----- design/hsp_obuf.sv -----
module hsp_obuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  hsp_pkg::t_rgb i_data,
    input  logic          i_stall,
    output logic          o_valid,
    output hsp_pkg::t_rgb o_data,
    output logic          o_full
);

    logic          r_out_vld;
    logic          r_skid_vld;
    hsp_pkg::t_rgb r_out;
    hsp_pkg::t_rgb r_skid;
    logic          w_take;

    assign w_take = r_out_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || w_take) begin
            r_out_vld <= i_vld;
        end else if (i_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || w_take) begin
            if (i_vld) begin
                r_out <= i_data;
            end
        end else if (i_vld) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;
    assign o_full  = r_skid_vld;

endmodule

// ----- design/hue_sat_picker_to_rgb.sv -----
// Picker position and brightness to RGB colour, in HSV sector form.
// Input channel: i_valid with o_stall; a request carries x, y and a
// brightness in percent. Output channel: o_valid with i_stall; each
// request yields exactly one red, green and blue triple scaled to 65025.
// Width and height are written through i_cfg_we, i_cfg_idx and
// i_cfg_data; the user must write them only while no request is in flight, as the block does not enforce it.
// From acceptance to o_valid a request passes one input register, FRAC_BITS + 3
// restoring division stages running side by side for hue and saturation, with the
// value taken from a reciprocal multiplication and delayed alongside,
// four arithmetic stages and the output register.
// Throughput is one request per cycle while o_stall is low. A skid register behind the output
// register absorbs one result when the receiver stalls; o_stall rises
// only once that skid register is full, and the whole pipeline then holds.
// Reset clears all valid bits and sets width and height to 100; the block
// accepts requests from the first cycle after reset.
module hue_sat_picker_to_rgb #(
    parameter int COORD_BITS = hsp_pkg::COORD_BITS,
    parameter int FRAC_BITS  = hsp_pkg::FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [COORD_BITS-1:0]            i_x_position,
    input  logic [COORD_BITS-1:0]            i_y_position,
    input  logic [hsp_pkg::BRIGHT_BITS-1:0]  i_brightness_percent,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [hsp_pkg::CH_BITS-1:0]      o_red,
    output logic [hsp_pkg::CH_BITS-1:0]      o_green,
    output logic [hsp_pkg::CH_BITS-1:0]      o_blue,
    input  logic                             i_cfg_we,
    input  logic [hsp_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS:0]              i_cfg_data
);

    localparam int REG_BITS  = COORD_BITS + 1;
    localparam int NXB       = COORD_BITS + 3;
    localparam int QB        = FRAC_BITS + 3;
    localparam int BB        = hsp_pkg::BRIGHT_BITS;
    localparam int VAL_SHIFT = 12;
    localparam int VB        = BB + FRAC_BITS + 6;
    localparam logic [FRAC_BITS+5:0] VAL_RECIP =
        (FRAC_BITS+6)'(((64'd1 << (FRAC_BITS + VAL_SHIFT)) + 64'(hsp_pkg::BRIGHT_MAX)
                        - 64'd1) / 64'(hsp_pkg::BRIGHT_MAX));

    logic [REG_BITS-1:0] r_width;
    logic [REG_BITS-1:0] r_height;
    logic [REG_BITS-1:0] w_w_eff;
    logic [REG_BITS-1:0] w_h_eff;
    logic [REG_BITS-1:0] w_x_sat;
    logic [REG_BITS-1:0] w_y_sat;
    logic [BB-1:0]       w_b_sat;
    logic [VB-1:0]       w_val_prod;

    logic                r_in_vld;
    logic [NXB-1:0]      r_num_x;
    logic [REG_BITS-1:0] r_num_s;
    logic [FRAC_BITS:0]  r_val;
    logic [FRAC_BITS:0]  r_val_dly [QB];
    logic [QB-1:0]       r_dv;

    logic [QB-1:0] w_hue_q;
    logic [QB-1:0] w_sat_q;

    logic          w_adv;
    logic          w_full;
    logic          w_calc_vld;
    hsp_pkg::t_rgb w_calc_rgb;
    hsp_pkg::t_rgb w_out_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= REG_BITS'(hsp_pkg::CFG_RESET);
            r_height <= REG_BITS'(hsp_pkg::CFG_RESET);
        end else if (i_cfg_we) begin
            case (hsp_pkg::t_cfg_idx'(i_cfg_idx))
                hsp_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                hsp_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_w_eff = (r_width == '0) ? REG_BITS'(1) : r_width;
    assign w_h_eff = (r_height == '0) ? REG_BITS'(1) : r_height;
    assign w_x_sat = ({1'b0, i_x_position} > w_w_eff) ? w_w_eff : {1'b0, i_x_position};
    assign w_y_sat = ({1'b0, i_y_position} > w_h_eff) ? w_h_eff : {1'b0, i_y_position};
    assign w_b_sat = (i_brightness_percent > BB'(hsp_pkg::BRIGHT_MAX))
                   ? BB'(hsp_pkg::BRIGHT_MAX) : i_brightness_percent;
    assign w_val_prod = VB'(w_b_sat) * VB'(VAL_RECIP);

    assign w_adv   = !w_full;
    assign o_stall = w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_dv     <= '0;
        end else if (w_adv) begin
            r_in_vld <= i_valid;
            r_dv     <= {r_dv[QB-2:0], r_in_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_num_x      <= {2'b00, w_x_sat} * NXB'(6);
            r_num_s      <= w_h_eff - w_y_sat;
            r_val        <= w_val_prod[FRAC_BITS+VAL_SHIFT:VAL_SHIFT];
            r_val_dly[0] <= r_val;
            for (int k = 1; k < QB; k++) begin
                r_val_dly[k] <= r_val_dly[k-1];
            end
        end
    end

    hsp_div_pipe #(
        .NB (NXB + FRAC_BITS),
        .DB (REG_BITS),
        .QB (QB)
    ) u_div_hue (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_num ({r_num_x, {FRAC_BITS{1'b0}}}),
        .i_den (w_w_eff),
        .o_quo (w_hue_q)
    );

    hsp_div_pipe #(
        .NB (REG_BITS + FRAC_BITS),
        .DB (REG_BITS),
        .QB (QB)
    ) u_div_sat (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_num ({r_num_s, {FRAC_BITS{1'b0}}}),
        .i_den (w_h_eff),
        .o_quo (w_sat_q)
    );

    hsp_calc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_vld    (r_dv[QB-1]),
        .i_sector (w_hue_q[QB-1:FRAC_BITS]),
        .i_frac   (w_hue_q[FRAC_BITS-1:0]),
        .i_sat    (w_sat_q[FRAC_BITS:0]),
        .i_val    (r_val_dly[QB-1]),
        .o_vld    (w_calc_vld),
        .o_rgb    (w_calc_rgb)
    );

    hsp_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_calc_vld),
        .i_data  (w_calc_rgb),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (w_out_rgb),
        .o_full  (w_full)
    );

    assign o_red   = w_out_rgb.red;
    assign o_green = w_out_rgb.green;
    assign o_blue  = w_out_rgb.blue;

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |=> $stable(r_dv) && $stable(r_in_vld))
        else $error("pipeline moved while the skid register was full");

    a_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red <= hsp_pkg::FULL_SCALE) && (o_green <= hsp_pkg::FULL_SCALE)
                    && (o_blue <= hsp_pkg::FULL_SCALE))
        else $error("channel above full scale");

    a_bright_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |-> (r_val <= {1'b1, {FRAC_BITS{1'b0}}}) && (r_num_s <= w_h_eff))
        else $error("input saturation failed");

endmodule
